// File: rtl/dmp_pkg.sv
// Shared constants for the decimal-to-milli parser: phase codes,
// character codes and numeric limits. No dependencies.
`default_nettype none

package dmp_pkg;

   // Parse phase codes
   localparam logic [2:0] PH_LEAD  = 3'd0;
   localparam logic [2:0] PH_INT   = 3'd1;
   localparam logic [2:0] PH_FRAC  = 3'd2;
   localparam logic [2:0] PH_TRAIL = 3'd3;
   localparam logic [2:0] PH_FAIL  = 3'd4;

   // Character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // Numeric widths and limits
   localparam int unsigned WHOLE_W   = 20;
   localparam int unsigned FRAC_W    = 10;
   localparam int unsigned MILLI_W   = 30;
   localparam logic [WHOLE_W-1:0] WHOLE_LIMIT = 20'd100000;
   localparam logic [9:0]         MILLI_SCALE = 10'd1000;

   // Number of fraction digits that carry weight
   localparam logic [1:0] FRAC_DIGITS = 2'd3;

endpackage

`default_nettype wire

// File: rtl/decimal_to_milli_parser_core.sv
// Decimal string parser producing an unsigned value in thousandths.
// Depends on dmp_pkg for phase codes, character codes and limits.
`default_nettype none

// Channel  | dir | tdata                      | tuser | tlast
// ---------+-----+----------------------------+-------+------
// req_     | in  | [7:0] ch                   |  --   |  --
// rsp_     | out | [29:0] milli_value, [31:30]=0 | ok |  --
//
// Each character passes through an input register, then the parser state
// updates from the registered character. One character per cycle is
// sustained while no terminator is stalled. A terminator (zero character)
// loads the result register from the input register, and stalls in the
// input register only while the result register holds an untaken result.
// Reset (synchronous, active high) clears the valid flags and parser state.

module decimal_to_milli_parser_core
   import dmp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] ch
   // response stream
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,   // [29:0] milli_value, [31:30] zero
   output      logic        rsp_tuser    // [0] ok
);

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_ch_ff,    in_ch_in;

   // Parser state
   logic [2:0]         phase_ff,    phase_in;
   logic [WHOLE_W-1:0] whole_ff,    whole_in;
   logic [FRAC_W-1:0]  frac_ff,     frac_in;
   logic [1:0]         frac_pos_ff, frac_pos_in;
   logic               seen_ff,     seen_in;

   // Result register
   logic               out_valid_ff, out_valid_in;
   logic               out_ok_ff,    out_ok_in;
   logic [MILLI_W-1:0] out_value_ff, out_value_in;

   // Datapath intermediates
   logic               is_term;
   logic               is_digit;
   logic [3:0]         digit;
   logic               out_free;
   logic               advance;
   logic [WHOLE_W+3:0] whole_x10;
   logic [WHOLE_W-1:0] whole_next;
   logic [6:0]         frac_weight;
   logic [10:0]        frac_add;
   logic               good;
   logic [MILLI_W-1:0] milli_sum;

   assign is_term  = (in_ch_ff == CH_NUL);
   assign is_digit = (in_ch_ff >= CH_ZERO) && (in_ch_ff <= CH_NINE);
   assign digit    = is_digit ? in_ch_ff[3:0] : 4'd0;

   // The result register can take a value when empty or being drained
   assign out_free = !out_valid_ff || rsp_tready;
   // Hold a terminator until the result slot is free; everything else moves
   assign advance  = in_valid_ff && (!is_term || out_free);

   assign req_tready = !in_valid_ff || advance;

   // whole * 10 + d, kept to 20 bits
   assign whole_x10  = {1'b0, whole_ff, 3'b000} + {3'b000, whole_ff, 1'b0}
                       + {{WHOLE_W{1'b0}}, digit};
   assign whole_next = whole_x10[WHOLE_W-1:0];

   always_comb begin
      unique case (frac_pos_ff)
         2'd0:    frac_weight = 7'd100;
         2'd1:    frac_weight = 7'd10;
         default: frac_weight = 7'd1;
      endcase
   end
   assign frac_add = {1'b0, frac_ff} + (11'(digit) * 11'(frac_weight));

   // Terminator result: whole * 1000 + frac, zero when not good
   assign good      = (phase_ff <= PH_TRAIL) && seen_ff;
   assign milli_sum = (MILLI_W'(whole_ff) * MILLI_W'(MILLI_SCALE))
                      + MILLI_W'(frac_ff);

   // Input register load
   always_comb begin
      in_valid_in = in_valid_ff;
      in_ch_in    = in_ch_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_ch_in    = req_tdata;
      end
   end

   // Parser state update
   always_comb begin
      phase_in    = phase_ff;
      whole_in    = whole_ff;
      frac_in     = frac_ff;
      frac_pos_in = frac_pos_ff;
      seen_in     = seen_ff;
      if (advance) begin
         if (is_term) begin
            // clear after emitting
            phase_in    = PH_LEAD;
            whole_in    = '0;
            frac_in     = '0;
            frac_pos_in = '0;
            seen_in     = 1'b0;
         end else begin
            unique case (phase_ff)
               PH_LEAD, PH_INT: begin
                  if (is_digit) begin
                     if (whole_ff > WHOLE_LIMIT) begin
                        phase_in = PH_FAIL;
                     end else begin
                        whole_in = whole_next;
                        seen_in  = 1'b1;
                        phase_in = PH_INT;
                     end
                  end else if (in_ch_ff == CH_DOT) begin
                     phase_in = PH_FRAC;
                  end else if (in_ch_ff == CH_SPACE) begin
                     // skip leading spaces, end the integer part otherwise
                     phase_in = (phase_ff == PH_LEAD) ? PH_LEAD : PH_TRAIL;
                  end else begin
                     phase_in = PH_FAIL;
                  end
               end
               PH_FRAC: begin
                  if (is_digit) begin
                     // drop digits past the third
                     if (frac_pos_ff < FRAC_DIGITS) begin
                        frac_in     = frac_add[FRAC_W-1:0];
                        frac_pos_in = frac_pos_ff + 2'd1;
                     end
                     seen_in = 1'b1;
                  end else if (in_ch_ff == CH_SPACE) begin
                     phase_in = PH_TRAIL;
                  end else begin
                     phase_in = PH_FAIL;
                  end
               end
               PH_TRAIL: begin
                  if (in_ch_ff != CH_SPACE) begin
                     phase_in = PH_FAIL;
                  end
               end
               default: begin
                  phase_in = PH_FAIL;
               end
            endcase
         end
      end
   end

   // Result register: load on an advancing terminator, drop once taken
   always_comb begin
      out_valid_in = out_valid_ff;
      out_ok_in    = out_ok_ff;
      out_value_in = out_value_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance && is_term) begin
         out_valid_in = 1'b1;
         out_ok_in    = good;
         out_value_in = good ? milli_sum : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_LEAD;
         whole_ff     <= '0;
         frac_ff      <= '0;
         frac_pos_ff  <= '0;
         seen_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         whole_ff     <= whole_in;
         frac_ff      <= frac_in;
         frac_pos_ff  <= frac_pos_in;
         seen_ff      <= seen_in;
      end
   end

   // Payload registers need no reset
   always_ff @(posedge clock) begin
      in_ch_ff     <= in_ch_in;
      out_ok_ff    <= out_ok_in;
      out_value_ff <= out_value_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ok_ff;
   assign rsp_tdata  = {2'b00, out_value_ff};

endmodule

`default_nettype wire
